@@ rtl/pps_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Preemptive priority scheduler package
// Item types, status codes and the job table record shared by the block.
// ---------------------------------------------------------------------------
package pps_pkg;

  localparam int unsigned MaxJobs = 16;

  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'd0,
    ST_REJECT = 3'd1,
    ST_IDLE   = 3'd2,
    ST_RAN    = 3'd3,
    ST_DONE   = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  job_id;
    logic [15:0] burst_time;
    logic [7:0]  priority_req;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  out_job_id;
    logic [15:0] time_now;
    logic [15:0] start_time;
    logic [15:0] waiting_time;
    logic [15:0] turnaround_time;
  } res_t;

  // One entry of the job table memory.
  typedef struct packed {
    logic [7:0]  job_id;
    logic [7:0]  prio;
    logic [15:0] remaining;
    logic [15:0] burst;
    logic [15:0] arrival;
    logic [15:0] start;
  } slot_t;

endpackage

@@ rtl/preemptive_priority_scheduler_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Preemptive priority scheduler core
// Job table with a sequencer that scans it through one shared comparator.
// ---------------------------------------------------------------------------
// The block takes one item at a time and holds in_stall_o high until that
// item's result is in the output register. An arrive item with a zero burst
// is rejected without a walk; any other arrive item walks the valid bits
// from slot 0 up to the first free slot, looking at no more than MAX_JOBS
// slots. For a tick item the job table memory is read one entry per cycle
// and each valid entry passes the single priority/id comparator, then the
// EXEC state updates the chosen job and the RESP state loads the result.
// A result that is not taken delays the next item's result, not its
// acceptance. Valid bits live in flip-flops, so no clearing pass is needed
// after reset.
module preemptive_priority_scheduler_core
  import pps_pkg::*;
#(
  parameter int unsigned MAX_JOBS = MaxJobs
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  cmd_t in_item_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_item_o
);

  localparam int unsigned IdxW = $clog2(MAX_JOBS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_JOBS - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIND  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_SLAST = 6'b001000,
    S_EXEC  = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  cmd_t cmd_q, cmd_d;
  res_t res_q, res_d;
  res_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic [MAX_JOBS-1:0] valid_q, valid_d;
  logic [MAX_JOBS-1:0] started_q, started_d;
  logic [15:0] time_q, time_d;
  logic best_found_q, best_found_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  slot_t best_rec_q, best_rec_d;
  logic cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_idx_q;

  slot_t mem_q [MAX_JOBS];
  slot_t rd_q;
  logic mem_we;
  logic [IdxW-1:0] mem_waddr;
  slot_t mem_wdata;

  logic out_take, out_free;
  logic [15:0] t_next, start_v, rem_v, ta_v;

  assign out_take = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

  assign t_next  = time_q + 16'd1;
  assign start_v = started_q[best_idx_q] ? best_rec_q.start : time_q;
  assign rem_v   = best_rec_q.remaining - 16'd1;
  assign ta_v    = t_next - best_rec_q.arrival;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cmd_d        = cmd_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_take;
    valid_d      = valid_q;
    started_d    = started_q;
    time_d       = time_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_rec_d   = best_rec_q;
    cmp_vld_d    = (state_q == S_SCAN) && valid_q[idx_q];
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = best_rec_q;

    // Shared comparator: strict less keeps the lower slot on a full tie.
    if (cmp_vld_q && (!best_found_q || (rd_q.prio < best_rec_q.prio) ||
        ((rd_q.prio == best_rec_q.prio) && (rd_q.job_id < best_rec_q.job_id)))) begin
      best_found_d = 1'b1;
      best_rec_d   = rd_q;
      best_idx_d   = cmp_idx_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = in_item_i;
          idx_d        = '0;
          best_found_d = 1'b0;
          if (in_item_i.command == CMD_TICK) begin
            state_d = S_SCAN;
          end else if (in_item_i.burst_time == 16'd0) begin
            res_d   = '{ST_REJECT, in_item_i.job_id, time_q, 16'd0, 16'd0, 16'd0};
            state_d = S_RESP;
          end else begin
            state_d = S_FIND;
          end
        end
      end
      S_FIND: begin
        if (!valid_q[idx_q]) begin
          mem_we         = 1'b1;
          mem_wdata      = '{cmd_q.job_id, cmd_q.priority_req, cmd_q.burst_time,
                             cmd_q.burst_time, time_q, 16'd0};
          valid_d[idx_q]   = 1'b1;
          started_d[idx_q] = 1'b0;
          res_d   = '{ST_ACCEPT, cmd_q.job_id, time_q, 16'd0, 16'd0, 16'd0};
          state_d = S_RESP;
        end else if (idx_q == LastIdx) begin
          res_d   = '{ST_REJECT, cmd_q.job_id, time_q, 16'd0, 16'd0, 16'd0};
          state_d = S_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SCAN: begin
        if (idx_q == LastIdx) begin
          state_d = S_SLAST;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SLAST: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        time_d  = t_next;
        state_d = S_RESP;
        if (!best_found_q) begin
          res_d = '{ST_IDLE, 8'd0, t_next, 16'd0, 16'd0, 16'd0};
        end else if (rem_v == 16'd0) begin
          res_d = '{ST_DONE, best_rec_q.job_id, t_next, start_v,
                    ta_v - best_rec_q.burst, ta_v};
          valid_d[best_idx_q]   = 1'b0;
          started_d[best_idx_q] = 1'b0;
        end else begin
          mem_we              = 1'b1;
          mem_waddr           = best_idx_q;
          mem_wdata.remaining = rem_v;
          mem_wdata.start     = start_v;
          started_d[best_idx_q] = 1'b1;
          res_d = '{ST_RAN, best_rec_q.job_id, t_next, start_v, 16'd0, 16'd0};
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      valid_q      <= '0;
      started_q    <= '0;
      time_q       <= 16'd0;
      best_found_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      valid_q      <= valid_d;
      started_q    <= started_d;
      time_q       <= time_d;
      best_found_q <= best_found_d;
      cmp_vld_q    <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cmd_q      <= cmd_d;
    res_q      <= res_d;
    out_q      <= out_d;
    best_idx_q <= best_idx_d;
    best_rec_q <= best_rec_d;
    cmp_idx_q  <= idx_q;
  end

  // Job table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[idx_q];
  end

  // Every tick advances the clock by exactly one unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> (time_q == $past(time_q) + 16'd1))
    else $error("tick did not advance the clock by one");

  // A job on its last unit leaves the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && best_found_q && best_rec_q.remaining == 16'd1)
    |=> !valid_q[$past(best_idx_q)])
    else $error("finished job still holds its slot");

  // A slot can only be marked started while it holds a job.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((started_q & ~valid_q) == '0))
    else $error("started flag set on a free slot");

  // A pending result moves to the output as soon as the output is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("pending result was not loaded");

  // Arrival never rejects while a free slot exists and the burst is nonzero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND && !valid_q[idx_q]) |=> (res_q.status == ST_ACCEPT))
    else $error("arrival with a free slot was not accepted");

endmodule
